// ===== design/itaf_pkg.sv =====
// Shared types, constants and control program of the integer to ASCII formatter
`timescale 1ns / 1ps

package itaf_pkg;

  localparam int VALUE_W  = 32;
  localparam int WIDTH_W  = 6;
  localparam int BUDGET_W = 7;
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 4;
  localparam int STEP_W   = 4;
  localparam int PROD_W   = 64;

  // decimal quotient: floor(x / 10) == (x * DEC_RECIP) >> DEC_SHIFT for every 32-bit x
  localparam logic [VALUE_W-1:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam int                 DEC_SHIFT = 35;

  // characters
  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } base_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic                is_signed;
    logic [1:0]          base_select;
    logic [WIDTH_W-1:0]  field_width;
    logic                zero_pad;
    logic                plus_flag;
    logic                space_flag;
    logic                upper_case;
    logic [BUDGET_W-1:0] budget;
  } num_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   out_char;
    logic                last;
    logic [BUDGET_W-1:0] budget_left;
  } char_item_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_LOAD       = 4'd1,
    OP_MUL        = 4'd2,
    OP_DIGIT      = 4'd3,
    OP_PREP       = 4'd4,
    OP_EMIT_SIGN  = 4'd5,
    OP_EMIT_ZERO  = 4'd6,
    OP_EMIT_SPACE = 4'd7,
    OP_EMIT_DIGIT = 4'd8
  } op_t;

  // sequencer branch conditions
  typedef enum logic [2:0] {
    COND_NEXT      = 3'd0,
    COND_JUMP      = 3'd1,
    COND_WAIT      = 3'd2,
    COND_QUOT_NZ   = 3'd3,
    COND_NO_SPACE  = 3'd4,
    COND_SPACE_PAD = 3'd5,
    COND_PHASE     = 3'd6
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // program steps
  localparam logic [STEP_W-1:0] STEP_WAIT    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MUL     = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DIV     = 4'd2;
  localparam logic [STEP_W-1:0] STEP_PREP    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_CHECK   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ORDER   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SIGN_Z  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_PAD_Z   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_PAD_S   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_SIGN_S  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_DIGITS  = 4'd10;

  // control store
  function automatic ctrl_word_t prog_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    unique case (step)
      STEP_WAIT:   w = '{op: OP_LOAD,       cond: COND_WAIT,      target: STEP_WAIT};
      STEP_MUL:    w = '{op: OP_MUL,        cond: COND_NEXT,      target: STEP_WAIT};
      STEP_DIV:    w = '{op: OP_DIGIT,      cond: COND_QUOT_NZ,   target: STEP_MUL};
      STEP_PREP:   w = '{op: OP_PREP,       cond: COND_NEXT,      target: STEP_WAIT};
      STEP_CHECK:  w = '{op: OP_NONE,       cond: COND_NO_SPACE,  target: STEP_WAIT};
      STEP_ORDER:  w = '{op: OP_NONE,       cond: COND_SPACE_PAD, target: STEP_PAD_S};
      STEP_SIGN_Z: w = '{op: OP_EMIT_SIGN,  cond: COND_PHASE,     target: STEP_PAD_Z};
      STEP_PAD_Z:  w = '{op: OP_EMIT_ZERO,  cond: COND_PHASE,     target: STEP_DIGITS};
      STEP_PAD_S:  w = '{op: OP_EMIT_SPACE, cond: COND_PHASE,     target: STEP_SIGN_S};
      STEP_SIGN_S: w = '{op: OP_EMIT_SIGN,  cond: COND_PHASE,     target: STEP_DIGITS};
      STEP_DIGITS: w = '{op: OP_EMIT_DIGIT, cond: COND_PHASE,     target: STEP_WAIT};
      default:     w = '{op: OP_NONE,       cond: COND_JUMP,      target: STEP_WAIT};
    endcase
    return w;
  endfunction

  // digit value to ASCII
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = (upper ? CH_UPPER_A : CH_LOWER_A) + CHAR_W'(d) - CHAR_W'(10);
    end
    return c;
  endfunction

endpackage

// ===== design/itaf_if.sv =====
// Handshake channels for formatter requests and output characters
`timescale 1ns / 1ps

interface itaf_num_if;
  logic                 valid;
  logic                 ready;
  itaf_pkg::num_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface itaf_char_if;
  logic                 valid;
  logic                 ready;
  itaf_pkg::char_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/integer_to_ascii_formatter_core.sv =====
// Microcoded integer to ASCII formatter: sequencer, digit datapath and output register
// A request runs the digit loop, then the prep, check and order steps, then emission.
// Requests are taken only in the wait step, so a new one waits until the last ends.
//   The two-step digit loop (multiply, then quotient and remainder) runs per digit,
//   and one character per cycle passes the output register unless text.ready stalls.
// Reset: synchronous, clears the step counter, counters and output valid; the digit
//   store is not cleared, every entry is written before it is read.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_core #(
  parameter int DIGIT_SLOTS = 32,
  parameter int MAX_OUT     = 64
) (
  input  logic         clk,
  input  logic         rst,
  itaf_num_if.sink     number,
  itaf_char_if.source  text
);

  localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);
  localparam int IDX_W = $clog2(DIGIT_SLOTS);
  localparam int TOT_W = $clog2(DIGIT_SLOTS + 66);

  localparam int VW = itaf_pkg::VALUE_W;
  localparam int BW = itaf_pkg::BUDGET_W;
  localparam int CW = itaf_pkg::CHAR_W;
  localparam int WW = itaf_pkg::WIDTH_W;
  localparam int DW = itaf_pkg::DIGIT_W;

  // sequencer and request state
  logic [itaf_pkg::STEP_W-1:0] step, step_next;
  logic [VW-1:0]                mag;
  logic [itaf_pkg::PROD_W-1:0]  prod;
  logic [CW-1:0]                sign_char;
  itaf_pkg::base_t              base_sel;
  logic                         zero_pad;
  logic                         upper;
  logic [WW-1:0]                field_width;
  logic [CNT_W-1:0]             digit_count;
  logic [WW-1:0]                pad_count;
  logic [TOT_W-1:0]             chars_left;
  logic [BW-1:0]                space_left;

  // digit store
  logic [DW-1:0]    digit_store [DIGIT_SLOTS];
  logic [DW-1:0]    rd_data;
  logic [IDX_W-1:0] rd_addr;

  // output register
  logic              out_valid;
  itaf_pkg::char_item_t out_data;

  itaf_pkg::ctrl_word_t cw;
  logic                 accept;
  logic                 slot_free;
  logic                 has_char;
  logic                 fire;
  logic                 emit_last;
  logic                 phase_end;
  logic [CW-1:0]        emit_char;
  logic [VW-1:0]        quot;
  logic [DW-1:0]        digit;
  logic [VW-1:0]        dec_rest;
  logic [VW-1:0]        neg_value;
  logic                 negative;
  logic [WW-1:0]        pad_calc;
  logic [BW-1:0]        budget_sat;

  assign cw        = itaf_pkg::prog_rom(step);
  assign accept    = number.valid && number.ready;
  assign number.ready = (step == itaf_pkg::STEP_WAIT);
  assign slot_free = !out_valid || text.ready;

  assign text.valid = out_valid;
  assign text.data  = out_data;

  // request decode
  assign negative   = number.data.is_signed && number.data.value[VW-1];
  assign neg_value  = VW'(0) - number.data.value;
  assign budget_sat = (32'(number.data.budget) > MAX_OUT) ? BW'(MAX_OUT) : number.data.budget;

  // one digit: shifts for powers of two, reciprocal product for decimal
  always_comb begin
    dec_rest = '0;
    case (base_sel)
      itaf_pkg::BASE_BIN: begin
        quot  = {1'b0, mag[VW-1:1]};
        digit = DW'(mag[0]);
      end
      itaf_pkg::BASE_OCT: begin
        quot  = {3'b0, mag[VW-1:3]};
        digit = DW'(mag[2:0]);
      end
      itaf_pkg::BASE_DEC: begin
        quot     = VW'(prod[itaf_pkg::PROD_W-1:itaf_pkg::DEC_SHIFT]);
        dec_rest = mag - ({quot[VW-4:0], 3'b0} + {quot[VW-2:0], 1'b0});
        digit    = dec_rest[DW-1:0];
      end
      default: begin
        quot  = {4'b0, mag[VW-1:4]};
        digit = mag[3:0];
      end
    endcase
  end

  // pad length ahead of the digits
  assign pad_calc = (TOT_W'(field_width) > TOT_W'(digit_count))
                  ? WW'(TOT_W'(field_width) - TOT_W'(digit_count)) : '0;

  // character of the current emit step
  always_comb begin
    has_char  = 1'b0;
    phase_end = 1'b1;
    emit_char = itaf_pkg::CH_NONE;
    case (cw.op)
      itaf_pkg::OP_EMIT_SIGN: begin
        has_char  = (sign_char != itaf_pkg::CH_NONE);
        emit_char = sign_char;
      end
      itaf_pkg::OP_EMIT_ZERO: begin
        has_char  = (pad_count != '0);
        phase_end = (pad_count == WW'(1));
        emit_char = itaf_pkg::CH_ZERO;
      end
      itaf_pkg::OP_EMIT_SPACE: begin
        has_char  = (pad_count != '0);
        phase_end = (pad_count == WW'(1));
        emit_char = itaf_pkg::CH_SPACE;
      end
      itaf_pkg::OP_EMIT_DIGIT: begin
        has_char  = (digit_count != '0);
        phase_end = (digit_count == CNT_W'(1));
        emit_char = itaf_pkg::digit_char(rd_data, upper);
      end
      default: begin
        has_char = 1'b0;
      end
    endcase
  end

  assign fire      = has_char && slot_free;
  assign emit_last = (space_left == BW'(1)) || (chars_left == TOT_W'(1));

  // next step of the program
  always_comb begin
    step_next = step + itaf_pkg::STEP_W'(1);
    case (cw.cond)
      itaf_pkg::COND_NEXT:      step_next = step + itaf_pkg::STEP_W'(1);
      itaf_pkg::COND_JUMP:      step_next = cw.target;
      itaf_pkg::COND_WAIT:      if (!accept) step_next = cw.target;
      itaf_pkg::COND_QUOT_NZ:   if (quot != '0) step_next = cw.target;
      itaf_pkg::COND_NO_SPACE:  if (space_left == '0) step_next = cw.target;
      itaf_pkg::COND_SPACE_PAD: if (!zero_pad) step_next = cw.target;
      itaf_pkg::COND_PHASE: begin
        if (!has_char) begin
          step_next = cw.target;
        end else if (!fire) begin
          step_next = step;
        end else if (emit_last) begin
          step_next = itaf_pkg::STEP_WAIT;
        end else if (phase_end) begin
          step_next = cw.target;
        end else begin
          step_next = step;
        end
      end
      default: step_next = itaf_pkg::STEP_WAIT;
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= itaf_pkg::STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
      pad_count   <= '0;
      chars_left  <= '0;
      space_left  <= '0;
      sign_char   <= itaf_pkg::CH_NONE;
    end else begin
      case (cw.op)
        itaf_pkg::OP_LOAD: begin
          if (accept) begin
            mag         <= negative ? neg_value : number.data.value;
            sign_char   <= negative                  ? itaf_pkg::CH_MINUS :
                           number.data.plus_flag     ? itaf_pkg::CH_PLUS  :
                           number.data.space_flag    ? itaf_pkg::CH_SPACE :
                                                       itaf_pkg::CH_NONE;
            base_sel    <= itaf_pkg::base_t'(number.data.base_select);
            zero_pad    <= number.data.zero_pad;
            upper       <= number.data.upper_case;
            field_width <= number.data.field_width;
            space_left  <= budget_sat;
            digit_count <= '0;
          end
        end
        itaf_pkg::OP_MUL: begin
          prod <= mag * itaf_pkg::DEC_RECIP;
        end
        itaf_pkg::OP_DIGIT: begin
          mag <= quot;
          if (32'(digit_count) < DIGIT_SLOTS) begin
            digit_count <= digit_count + CNT_W'(1);
          end
        end
        itaf_pkg::OP_PREP: begin
          pad_count  <= pad_calc;
          chars_left <= TOT_W'(pad_calc) + TOT_W'(digit_count)
                      + TOT_W'(sign_char != itaf_pkg::CH_NONE);
        end
        itaf_pkg::OP_EMIT_SIGN, itaf_pkg::OP_EMIT_ZERO,
        itaf_pkg::OP_EMIT_SPACE, itaf_pkg::OP_EMIT_DIGIT: begin
          if (fire) begin
            space_left <= space_left - BW'(1);
            chars_left <= chars_left - TOT_W'(1);
            if (cw.op == itaf_pkg::OP_EMIT_ZERO || cw.op == itaf_pkg::OP_EMIT_SPACE) begin
              pad_count <= pad_count - WW'(1);
            end
            if (cw.op == itaf_pkg::OP_EMIT_DIGIT) begin
              digit_count <= digit_count - CNT_W'(1);
            end
          end
        end
        default: begin
          space_left <= space_left;
        end
      endcase
    end
  end

  // digit store: write during extraction, registered read for emission
  assign rd_addr = (fire && cw.op == itaf_pkg::OP_EMIT_DIGIT)
                 ? IDX_W'(digit_count - CNT_W'(2))
                 : IDX_W'(digit_count - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cw.op == itaf_pkg::OP_DIGIT && 32'(digit_count) < DIGIT_SLOTS) begin
      digit_store[IDX_W'(digit_count)] <= digit;
    end
    rd_data <= digit_store[rd_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (text.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.out_char    <= emit_char;
      out_data.last        <= emit_last;
      out_data.budget_left <= space_left - BW'(1);
    end
  end

  // a character never goes out without space for it
  a_space_on_fire: assert property (@(posedge clk) disable iff (rst)
    fire |-> space_left != '0)
    else $error("character emitted with no space left");

  // the final character returns the program to the wait step
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (fire && emit_last) |=> step == itaf_pkg::STEP_WAIT)
    else $error("sequencer kept running after the final character");

  // a new request clears the digit count and starts at the multiply step
  a_accept_clears: assert property (@(posedge clk) disable iff (rst)
    accept |=> digit_count == '0 && step == itaf_pkg::STEP_MUL)
    else $error("request did not start a fresh conversion");

  // the digit count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(digit_count) <= DIGIT_SLOTS)
    else $error("digit count beyond the store");

  // a character that uses the last of the budget is marked as the final one
  a_budget_order: assert property (@(posedge clk) disable iff (rst)
    (fire && space_left == BW'(1)) |-> emit_last)
    else $error("budget exhausted without marking the final character");

endmodule
